// ===== src/dtw_pkg.sv =====
package dtw_pkg;

   localparam int DTW_SLOTS    = 64;
   localparam int DTW_SLOT_CAP = 16;

   // The jitter counter runs 0..JITTER_TOP and then wraps.
   localparam int JITTER_W   = 4;
   localparam int JITTER_TOP = 8;
   localparam int DELAY_W    = 8;
   localparam int DLY_SUM_W  = DELAY_W + 1;

   typedef enum logic {
      KIND_REGISTER,
      KIND_TICK
   } dtw_kind_type;

   typedef struct packed {
      logic [15:0]        sound;
      logic [15:0]        volume;
      logic signed [15:0] pan;
      logic [15:0]        rate;
      logic [15:0]        source;
   } dtw_event_type;

   typedef struct packed {
      logic ev_we;
      logic fill_we;
      logic fill_clr;
   } dtw_mem_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REG_SLOT,
      ST_REG_WRITE,
      ST_TICK_ADV,
      ST_TICK_FILL,
      ST_TICK_RD,
      ST_TICK_OUT
   } dtw_state_type;

endpackage

// ===== src/dtw_wrap_unit.sv =====
module dtw_wrap_unit
   import dtw_pkg::*;
#(
   parameter int SLOTS  = DTW_SLOTS,
   localparam int SLOT_W = $clog2(SLOTS)
) (
   input  logic [SLOT_W-1:0] a,
   input  logic [SLOT_W-1:0] b,
   output logic [SLOT_W-1:0] y
);

   logic [SLOT_W:0] sum;

   // Both operands are below SLOTS, so one compare and subtract wraps the sum.
   always_comb begin
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= (SLOT_W + 1)'(SLOTS)) begin
         y = SLOT_W'(sum - (SLOT_W + 1)'(SLOTS));
      end else begin
         y = sum[SLOT_W-1:0];
      end
   end

endmodule

// ===== src/dtw_store.sv =====
module dtw_store
   import dtw_pkg::*;
#(
   parameter int SLOTS    = DTW_SLOTS,
   parameter int SLOT_CAP = DTW_SLOT_CAP,
   localparam int SLOT_W  = $clog2(SLOTS),
   localparam int FILL_W  = $clog2(SLOT_CAP + 1),
   localparam int DEPTH   = SLOTS * SLOT_CAP,
   localparam int ADDR_W  = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  dtw_mem_cmd_type   cmd,
   input  logic [SLOT_W-1:0] fill_addr,
   input  logic [FILL_W-1:0] fill_wdata,
   output logic [FILL_W-1:0] fill_rdata,
   input  logic [ADDR_W-1:0] ev_addr,
   input  dtw_event_type     ev_wdata,
   output dtw_event_type     ev_rdata
);

   logic [FILL_W-1:0] fill_mem [SLOTS];
   dtw_event_type     ev_mem [DEPTH];
   logic [FILL_W-1:0] fill_q_ff;
   logic [SLOTS-1:0]  fill_vld_ff;
   logic              vld_q_ff;
   dtw_event_type     ev_q_ff;

   // A slot whose valid bit is clear holds no events, whatever its fill entry says.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_vld_ff <= '0;
      end else if (cmd.fill_clr) begin
         fill_vld_ff[fill_addr] <= 1'b0;
      end else if (cmd.fill_we) begin
         fill_vld_ff[fill_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fill_we) begin
         fill_mem[fill_addr] <= fill_wdata;
      end
      fill_q_ff <= fill_mem[fill_addr];
      vld_q_ff  <= fill_vld_ff[fill_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.ev_we) begin
         ev_mem[ev_addr] <= ev_wdata;
      end
      ev_q_ff <= ev_mem[ev_addr];
   end

   assign fill_rdata = vld_q_ff ? fill_q_ff : '0;
   assign ev_rdata   = ev_q_ff;

endmodule

// ===== src/dtw_ctrl.sv =====
module dtw_ctrl
   import dtw_pkg::*;
#(
   parameter int SLOTS    = DTW_SLOTS,
   parameter int SLOT_CAP = DTW_SLOT_CAP,
   localparam int SLOT_W  = $clog2(SLOTS),
   localparam int FILL_W  = $clog2(SLOT_CAP + 1),
   localparam int ADDR_W  = $clog2(SLOTS * SLOT_CAP)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  dtw_event_type      req_event,
   input  logic [DELAY_W-1:0] req_delay,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output dtw_event_type      rsp_event,
   output logic               rsp_last,
   output logic [SLOT_W-1:0]  wrap_a,
   output logic [SLOT_W-1:0]  wrap_b,
   input  logic [SLOT_W-1:0]  wrap_y,
   output dtw_mem_cmd_type    cmd,
   output logic [SLOT_W-1:0]  fill_addr,
   output logic [FILL_W-1:0]  fill_wdata,
   input  logic [FILL_W-1:0]  fill_rdata,
   output logic [ADDR_W-1:0]  ev_addr,
   output dtw_event_type      ev_wdata,
   input  dtw_event_type      ev_rdata
);

   dtw_state_type       state_ff, state_in;
   logic [SLOT_W-1:0]   cur_ff, cur_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [JITTER_W-1:0] jit_ff, jit_in;
   logic [FILL_W-1:0]   cnt_ff, cnt_in;
   logic [FILL_W-1:0]   num_ff, num_in;
   logic                rsp_valid_ff, rsp_valid_in;
   dtw_event_type       rsp_event_ff, rsp_event_in;
   logic                rsp_last_ff, rsp_last_in;
   dtw_event_type       evt_ff, evt_in;
   logic [DELAY_W-1:0]  dly_ff, dly_in;

   logic                accept;
   logic                out_free;
   logic                is_last;
   logic                slot_full;
   logic [DLY_SUM_W-1:0] dly_sum;
   logic [SLOT_W-1:0]   dly_clamp;
   logic [SLOT_W-1:0]   base_slot;
   logic [FILL_W-1:0]   offset;

   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_last   = (cnt_ff + FILL_W'(1)) == num_ff;
   assign slot_full = fill_rdata >= FILL_W'(SLOT_CAP);

   always_comb begin
      dly_sum = DLY_SUM_W'(dly_ff) + DLY_SUM_W'(jit_ff) + DLY_SUM_W'(1);
      if (dly_sum > DLY_SUM_W'(SLOTS - 1)) begin
         dly_clamp = SLOT_W'(SLOTS - 1);
      end else begin
         dly_clamp = dly_sum[SLOT_W-1:0];
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_kind == KIND_TICK) ? ST_TICK_ADV : ST_REG_SLOT;
            end
         end
         ST_REG_SLOT:  state_in = ST_REG_WRITE;
         ST_REG_WRITE: state_in = ST_IDLE;
         ST_TICK_ADV:  state_in = ST_TICK_FILL;
         ST_TICK_FILL: begin
            state_in = (fill_rdata == '0) ? ST_IDLE : ST_TICK_RD;
         end
         ST_TICK_RD:   state_in = ST_TICK_OUT;
         ST_TICK_OUT: begin
            if (out_free) begin
               state_in = is_last ? ST_IDLE : ST_TICK_RD;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      wrap_a       = cur_ff;
      wrap_b       = dly_clamp;
      fill_addr    = cur_ff;
      fill_wdata   = fill_rdata + FILL_W'(1);
      base_slot    = cur_ff;
      offset       = cnt_ff;
      ev_wdata     = evt_ff;
      cur_in       = cur_ff;
      slot_in      = slot_ff;
      jit_in       = jit_ff;
      cnt_in       = cnt_ff;
      num_in       = num_ff;
      evt_in       = evt_ff;
      dly_in       = dly_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_event_in = rsp_event_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               evt_in = req_event;
               dly_in = req_delay;
            end
         end
         ST_REG_SLOT: begin
            // The fill read is issued at the freshly computed target slot.
            slot_in   = wrap_y;
            fill_addr = wrap_y;
            jit_in    = (jit_ff >= JITTER_W'(JITTER_TOP)) ? '0 : jit_ff + JITTER_W'(1);
         end
         ST_REG_WRITE: begin
            fill_addr = slot_ff;
            base_slot = slot_ff;
            offset    = fill_rdata;
            if (!slot_full) begin
               cmd.ev_we   = 1'b1;
               cmd.fill_we = 1'b1;
            end
         end
         ST_TICK_ADV: begin
            wrap_b    = SLOT_W'(1);
            cur_in    = wrap_y;
            fill_addr = wrap_y;
            jit_in    = '0;
         end
         ST_TICK_FILL: begin
            cnt_in = '0;
            num_in = slot_full ? FILL_W'(SLOT_CAP) : fill_rdata;
            if (fill_rdata == '0) begin
               cmd.fill_clr = 1'b1;
            end
         end
         ST_TICK_RD: begin
         end
         ST_TICK_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_event_in = ev_rdata;
               rsp_last_in  = is_last;
               cnt_in       = cnt_ff + FILL_W'(1);
               cmd.fill_clr = is_last;
            end
         end
         default: begin
         end
      endcase
      ev_addr = ADDR_W'(ADDR_W'(base_slot) * ADDR_W'(SLOT_CAP)) + ADDR_W'(offset);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= '0;
         jit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         jit_ff       <= jit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      cnt_ff       <= cnt_in;
      num_ff       <= num_in;
      evt_ff       <= evt_in;
      dly_ff       <= dly_in;
      rsp_event_ff <= rsp_event_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_event = rsp_event_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

// ===== src/delayed_event_timing_wheel.sv =====
// Timing wheel of SLOTS slots holding up to SLOT_CAP delayed sound events each. A register
// request (kind 0) is accepted, then forms the target slot in the shared add-and-wrap unit while
// the slot's fill count is read, then writes the event and the new count unless the slot is full.
// A tick request (kind 1) is accepted, advances the current slot and reads its fill count; each
// due event then takes an event memory read and a load of the response register, which the
// response side can stall. Results stream out in insertion order, the final one marked by
// rsp_last. The event memory and the fill-count memory each have one port. Slot fill counts
// are qualified by a valid bit per slot, so no clearing pass follows reset and requests are
// taken from the first cycle after it.
module delayed_event_timing_wheel
   import dtw_pkg::*;
#(
   parameter int SLOTS    = DTW_SLOTS,
   parameter int SLOT_CAP = DTW_SLOT_CAP
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic [15:0]        req_sound_id,
   input  logic [15:0]        req_volume,
   input  logic signed [15:0] req_pan,
   input  logic [15:0]        req_rate,
   input  logic [7:0]         req_delay,
   input  logic [15:0]        req_source_id,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_out_sound,
   output logic [15:0]        rsp_out_volume,
   output logic signed [15:0] rsp_out_pan,
   output logic [15:0]        rsp_out_rate,
   output logic [15:0]        rsp_out_source,
   output logic               rsp_last
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int FILL_W = $clog2(SLOT_CAP + 1);
   localparam int ADDR_W = $clog2(SLOTS * SLOT_CAP);

   dtw_event_type     req_event;
   dtw_event_type     rsp_event;
   dtw_event_type     ev_wdata;
   dtw_event_type     ev_rdata;
   dtw_mem_cmd_type   cmd;
   logic [SLOT_W-1:0] wrap_a;
   logic [SLOT_W-1:0] wrap_b;
   logic [SLOT_W-1:0] wrap_y;
   logic [SLOT_W-1:0] fill_addr;
   logic [FILL_W-1:0] fill_wdata;
   logic [FILL_W-1:0] fill_rdata;
   logic [ADDR_W-1:0] ev_addr;

   always_comb begin
      req_event.sound  = req_sound_id;
      req_event.volume = req_volume;
      req_event.pan    = req_pan;
      req_event.rate   = req_rate;
      req_event.source = req_source_id;
   end

   assign rsp_out_sound  = rsp_event.sound;
   assign rsp_out_volume = rsp_event.volume;
   assign rsp_out_pan    = rsp_event.pan;
   assign rsp_out_rate   = rsp_event.rate;
   assign rsp_out_source = rsp_event.source;

   dtw_ctrl #(
      .SLOTS    (SLOTS),
      .SLOT_CAP (SLOT_CAP)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_kind   (req_kind),
      .req_event  (req_event),
      .req_delay  (req_delay),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_event  (rsp_event),
      .rsp_last   (rsp_last),
      .wrap_a     (wrap_a),
      .wrap_b     (wrap_b),
      .wrap_y     (wrap_y),
      .cmd        (cmd),
      .fill_addr  (fill_addr),
      .fill_wdata (fill_wdata),
      .fill_rdata (fill_rdata),
      .ev_addr    (ev_addr),
      .ev_wdata   (ev_wdata),
      .ev_rdata   (ev_rdata)
   );

   dtw_wrap_unit #(
      .SLOTS (SLOTS)
   ) u_wrap (
      .a (wrap_a),
      .b (wrap_b),
      .y (wrap_y)
   );

   dtw_store #(
      .SLOTS    (SLOTS),
      .SLOT_CAP (SLOT_CAP)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .fill_addr  (fill_addr),
      .fill_wdata (fill_wdata),
      .fill_rdata (fill_rdata),
      .ev_addr    (ev_addr),
      .ev_wdata   (ev_wdata),
      .ev_rdata   (ev_rdata)
   );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top
   import dtw_pkg::*;
();

   localparam int ITEM_TARGET  = 440;
   localparam int STALL_CYCLES = 400;
   localparam int TAIL_CYCLES  = 40;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      logic          kind;
      dtw_event_type ev;
      logic [7:0]    delay;
   } wheel_req_type;

   typedef struct packed {
      dtw_event_type ev;
      logic          last;
   } due_rec_type;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_ready;
   logic               req_kind       = 1'b0;
   logic [15:0]        req_sound_id   = '0;
   logic [15:0]        req_volume     = '0;
   logic signed [15:0] req_pan        = '0;
   logic [15:0]        req_rate       = '0;
   logic [7:0]         req_delay      = '0;
   logic [15:0]        req_source_id  = '0;
   logic               rsp_valid;
   logic               rsp_ready      = 1'b0;
   logic [15:0]        rsp_out_sound;
   logic [15:0]        rsp_out_volume;
   logic signed [15:0] rsp_out_pan;
   logic [15:0]        rsp_out_rate;
   logic [15:0]        rsp_out_source;
   logic               rsp_last;

   // Requests waiting to be offered, and the one currently on the bus.
   wheel_req_type pending [$];
   wheel_req_type offered;
   int unsigned req_issued  = 0;
   int unsigned req_taken   = 0;
   int unsigned total_items = 0;
   int unsigned stall_at    = '1;
   int unsigned pause_at    = '1;
   int unsigned stall_left  = 0;
   bit          stall_done  = 1'b0;
   int unsigned mismatches  = 0;
   int unsigned plan_jitter = 0;

   // Shadow copy of the wheel.
   dtw_event_type slot_events [DTW_SLOTS][DTW_SLOT_CAP];
   int unsigned   slot_count  [DTW_SLOTS];
   int unsigned   now_slot = 0;
   int unsigned   jitter   = 0;
   due_rec_type   due_events [$];

   delayed_event_timing_wheel i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_sound_id   (req_sound_id),
      .req_volume     (req_volume),
      .req_pan        (req_pan),
      .req_rate       (req_rate),
      .req_delay      (req_delay),
      .req_source_id  (req_source_id),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_sound  (rsp_out_sound),
      .rsp_out_volume (rsp_out_volume),
      .rsp_out_pan    (rsp_out_pan),
      .rsp_out_rate   (rsp_out_rate),
      .rsp_out_source (rsp_out_source),
      .rsp_last       (rsp_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void predict_request(input wheel_req_type r);
      int unsigned span;
      int unsigned target;
      due_rec_type rec;
      if (r.kind == KIND_TICK) begin
         now_slot = (now_slot + 1) % DTW_SLOTS;
         for (int k = 0; k < slot_count[now_slot]; k++) begin
            rec.ev   = slot_events[now_slot][k];
            rec.last = (k + 1 == slot_count[now_slot]);
            due_events.push_back(rec);
         end
         slot_count[now_slot] = 0;
         jitter = 0;
      end else begin
         span   = r.delay + 1 + jitter;
         jitter = (jitter >= JITTER_TOP) ? 0 : jitter + 1;
         if (span > DTW_SLOTS - 1)
            span = DTW_SLOTS - 1;
         target = (now_slot + span) % DTW_SLOTS;
         // A full slot drops the event without a trace.
         if (slot_count[target] < DTW_SLOT_CAP) begin
            slot_events[target][slot_count[target]] = r.ev;
            slot_count[target]++;
         end
      end
   endfunction

   function automatic dtw_event_type random_event();
      dtw_event_type ev;
      ev.sound  = 16'($urandom);
      ev.volume = 16'($urandom);
      ev.pan    = 16'($urandom);
      ev.rate   = 16'($urandom);
      ev.source = 16'($urandom);
      return ev;
   endfunction

   // The generator tracks the jitter count so that bursts can aim at one slot.
   function automatic void queue_register(input dtw_event_type ev, input logic [7:0] delay);
      wheel_req_type r;
      r.kind  = KIND_REGISTER;
      r.ev    = ev;
      r.delay = delay;
      pending.push_back(r);
      plan_jitter = (plan_jitter >= JITTER_TOP) ? 0 : plan_jitter + 1;
   endfunction

   function automatic void queue_tick();
      wheel_req_type r;
      r       = '0;
      r.kind  = KIND_TICK;
      r.ev    = random_event();
      r.delay = 8'($urandom);
      pending.push_back(r);
      plan_jitter = 0;
   endfunction

   function automatic int unsigned idle_pct(input bit sender);
      if (req_taken < total_items / 3)
         return sender ? 22 : 45;
      else if (req_taken < 2 * total_items / 3)
         return sender ? 45 : 22;
      return 0;
   endfunction

   always @(negedge clock) begin : drive_req
      wheel_req_type nxt;
      if (!reset) begin
         if (!req_valid || req_taken == req_issued) begin
            if (pending.size() != 0 &&
                !(req_issued == pause_at && due_events.size() != 0) &&
                $urandom_range(99) >= idle_pct(1'b1)) begin
               nxt           = pending.pop_front();
               offered       = nxt;
               req_kind      <= nxt.kind;
               req_sound_id  <= nxt.ev.sound;
               req_volume    <= nxt.ev.volume;
               req_pan       <= nxt.ev.pan;
               req_rate      <= nxt.ev.rate;
               req_delay     <= nxt.delay;
               req_source_id <= nxt.ev.source;
               req_valid     <= 1'b1;
               req_issued++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // One long hold-off lets the block back up into its request side.
   always @(negedge clock) begin : drive_rsp_ready
      if (!reset) begin
         if (!stall_done && req_taken >= stall_at) begin
            stall_left = STALL_CYCLES;
            stall_done = 1'b1;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= idle_pct(1'b0));
         end
      end
   end

   always @(posedge clock) begin : watch
      due_rec_type want;
      due_rec_type got;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got.ev.sound  = rsp_out_sound;
            got.ev.volume = rsp_out_volume;
            got.ev.pan    = rsp_out_pan;
            got.ev.rate   = rsp_out_rate;
            got.ev.source = rsp_out_source;
            got.last      = rsp_last;
            if (due_events.size() == 0) begin
               if (mismatches < REPORT_MAX)
                  $display("unexpected result: sound %h volume %h pan %h rate %h source %h last %b",
                           got.ev.sound, got.ev.volume, got.ev.pan, got.ev.rate,
                           got.ev.source, got.last);
               mismatches++;
            end else begin
               want = due_events.pop_front();
               if (got.ev.sound !== want.ev.sound || got.ev.volume !== want.ev.volume ||
                   got.ev.pan !== want.ev.pan || got.ev.rate !== want.ev.rate ||
                   got.ev.source !== want.ev.source || got.last !== want.last) begin
                  if (mismatches < REPORT_MAX) begin
                     $display("mismatch: want sound %h volume %h pan %h rate %h source %h last %b",
                              want.ev.sound, want.ev.volume, want.ev.pan, want.ev.rate,
                              want.ev.source, want.last);
                     $display("          got  sound %h volume %h pan %h rate %h source %h last %b",
                              got.ev.sound, got.ev.volume, got.ev.pan, got.ev.rate,
                              got.ev.source, got.last);
                  end
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_request(offered);
            req_taken++;
         end
      end
   end

   initial begin : run
      dtw_event_type ev;
      int unsigned   cyc;
      int unsigned   span;
      int unsigned   n;
      int unsigned   t;
      int unsigned   pick;

      // Tick on an empty slot, then seventeen events aimed at one slot so the
      // last one is dropped; field extremes ride along in the first few.
      queue_tick();
      for (int i = 0; i < DTW_SLOT_CAP + 1; i++) begin
         ev = random_event();
         case (i)
            0: ev = '0;
            1: ev = '1;
            2: ev.pan = 16'sh4000;
            3: ev.pan = -16'sh4000;
            4: ev.pan = 16'sh8000;
            5: ev.pan = 16'sh7fff;
            default: ;
         endcase
         queue_register(ev, 8'(8 - plan_jitter));
      end
      // The largest delay is clamped to the slot just behind the current one.
      queue_register(random_event(), 8'd255);
      repeat (9) queue_tick();

      while (pending.size() < ITEM_TARGET) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            span = ($urandom_range(9) == 0) ? $urandom_range(63, 9) : $urandom_range(14, 9);
            n    = ($urandom_range(3) == 0) ? $urandom_range(20, 12) : $urandom_range(8, 1);
            repeat (n) queue_register(random_event(), 8'(span - 1 - plan_jitter));
            t = ($urandom_range(3) == 0) ? $urandom_range(span, 1) : span + $urandom_range(2);
            repeat (t) queue_tick();
         end else if (pick < 80) begin
            repeat ($urandom_range(6, 1)) begin
               if ($urandom_range(9) < 3)
                  queue_tick();
               else
                  queue_register(random_event(),
                                 8'($urandom_range(1) ? $urandom_range(255) :
                                                        $urandom_range(12)));
            end
         end else begin
            repeat ($urandom_range(10, 1)) queue_tick();
         end
      end
      total_items = pending.size();
      stall_at    = total_items / 6;
      pause_at    = total_items / 2;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      cyc = 0;
      while (cyc < CYCLE_LIMIT &&
             !(pending.size() == 0 && req_taken == total_items && due_events.size() == 0)) begin
         @(posedge clock);
         cyc++;
      end
      if (cyc < CYCLE_LIMIT)
         repeat (TAIL_CYCLES) @(posedge clock);
      if (cyc < CYCLE_LIMIT && mismatches == 0 && due_events.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/dtw_pkg.sv
src/dtw_wrap_unit.sv
src/dtw_store.sv
src/dtw_ctrl.sv
src/delayed_event_timing_wheel.sv
sim/tb_top.sv
